// ===== hdl/lpr_pkg.sv =====
// Shared constants and types of the line pixel rasterizer.
// Used by the divider, the top level and the checker; no dependencies.
package lpr_pkg;

  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 16;
  // signed 2.16 slope, magnitude at most 1.0
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  // accumulator keeps only the bits that reach the minor coordinate
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
  // one quotient bit per divider step
  localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(QUO_BITS);

  localparam logic [FRAC_BITS-1:0] HALF_ONE = FRAC_BITS'(16'h8000);

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_value;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] num_mag;
    logic [COORD_BITS-1:0] den_mag;
    logic                  negate;
  } div_req_t;

  typedef struct packed {
    logic                         busy;
    logic signed [SLOPE_BITS-1:0] slope;
  } div_rsp_t;

endpackage

// ===== hdl/lpr_divider.sv =====
// Bit-serial restoring divider for the 2.16 line slope.
// Depends on lpr_pkg.
module lpr_divider
  import lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [COORD_BITS-1:0] rem_r;
  logic [COORD_BITS-1:0] rem_nxt;
  logic [QUO_BITS-1:0]   dq_r;
  logic [QUO_BITS-1:0]   dq_nxt;
  logic [COORD_BITS-1:0] den_r;
  logic                  neg_r;

  logic [COORD_BITS:0]   rem_sh;
  logic [COORD_BITS:0]   rem_diff;
  logic                  fits;
  logic [SLOPE_BITS-1:0] mag;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, dq_r[QUO_BITS-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
    rem_nxt  = fits ? rem_diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
    dq_nxt   = {dq_r[QUO_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_BITS'(QUO_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      rem_r <= '0;
      dq_r  <= {req.num_mag, {FRAC_BITS{1'b0}}};
      den_r <= req.den_mag;
      neg_r <= req.negate;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  // quotient never exceeds 1.0 since the minor delta is the shorter one
  always_comb begin
    mag = {1'b0, dq_r[SLOPE_BITS-2:0]};
    if (den_r == '0) begin
      rsp.slope = '0;
    end else if (neg_r) begin
      rsp.slope = -mag;
    end else begin
      rsp.slope = mag;
    end
    rsp.busy = busy_r | done_r;
  end

endmodule

// ===== hdl/line_pixel_rasterizer.sv =====
// Top level of the line pixel rasterizer: stepping datapath and output register.
// Depends on lpr_pkg and lpr_divider.
//
// Line rasteriser after the extremely fast line algorithm, 8.16 fixed point.
// A start transfer (kind = KIND_START) latches both endpoints and the colour,
// picks the longer axis (x on a tie) and emits the first pixel straight away;
// the input then stalls while a restoring divider produces the slope,
// one quotient bit per cycle. A start item therefore holds the input while
// the divider loads its operands, runs its COORD_BITS + 16 divide steps and
// hands over the slope. Each advance transfer (kind = KIND_ADVANCE) steps
// the major coordinate by one and the minor accumulator by the slope, and
// emits that pixel in the next cycle; advances are taken one per cycle
// while the output is not stalled. last marks the line's end pixel, after
// which advances are dropped without a result until the next start. A start
// while a line is active abandons it. Results sit in an output register;
// while a pixel waits there on out_stall the input stalls as well, and it
// frees again in the cycle the pixel is transferred.
module line_pixel_rasterizer
  import lpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // line state
  logic                         line_active_r, line_active_nxt;
  logic                         major_y_r, major_y_nxt;
  logic                         step_down_r, step_down_nxt;
  logic [COORD_BITS-1:0]        major_pos_r, major_pos_nxt;
  logic [COORD_BITS-1:0]        major_end_r, major_end_nxt;
  logic [ACC_BITS-1:0]          minor_acc_r, minor_acc_nxt;
  logic signed [SLOPE_BITS-1:0] slope_r;
  logic [COLOR_BITS-1:0]        color_r, color_nxt;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic accept, start_go, adv_go, emit;

  // start item setup
  logic signed [COORD_BITS:0] dx, dy, maj_len, min_len;
  logic [COORD_BITS:0]        adx, ady;
  logic                       y_major;
  logic [ACC_BITS-1:0]        slope_ext;
  logic [COORD_BITS-1:0]      minor_coord;
  logic                       last_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lpr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // stall while dividing, or while the output register is full and held
  assign in_stall  = div_rsp.busy | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign start_go  = accept & (in_data.kind == KIND_START);
  assign adv_go    = accept & (in_data.kind == KIND_ADVANCE) & line_active_r;
  assign emit      = start_go | adv_go;

  // axis choice and deltas for a start transfer
  always_comb begin
    dx      = $signed({1'b0, in_data.x_end}) - $signed({1'b0, in_data.x_start});
    dy      = $signed({1'b0, in_data.y_end}) - $signed({1'b0, in_data.y_start});
    adx     = dx[COORD_BITS] ? -dx : dx;
    ady     = dy[COORD_BITS] ? -dy : dy;
    y_major = (ady > adx);
    maj_len = y_major ? dy : dx;
    min_len = y_major ? dx : dy;

    div_req.start   = start_go;
    div_req.num_mag = y_major ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
    div_req.den_mag = y_major ? ady[COORD_BITS-1:0] : adx[COORD_BITS-1:0];
    div_req.negate  = min_len[COORD_BITS] ^ maj_len[COORD_BITS];
  end

  assign slope_ext = {{(ACC_BITS-SLOPE_BITS){slope_r[SLOPE_BITS-1]}}, slope_r};

  // next line state and the pixel it gives
  always_comb begin
    major_y_nxt   = major_y_r;
    step_down_nxt = step_down_r;
    major_pos_nxt = major_pos_r;
    major_end_nxt = major_end_r;
    minor_acc_nxt = minor_acc_r;
    color_nxt     = color_r;

    if (start_go) begin
      major_y_nxt   = y_major;
      step_down_nxt = maj_len[COORD_BITS] | (maj_len == '0);
      major_pos_nxt = y_major ? in_data.y_start : in_data.x_start;
      major_end_nxt = y_major ? in_data.y_end : in_data.x_end;
      minor_acc_nxt = {(y_major ? in_data.x_start : in_data.y_start), HALF_ONE};
      color_nxt     = in_data.pixel_color;
    end else if (adv_go) begin
      if (step_down_r) begin
        major_pos_nxt = major_pos_r - 1'b1;
        minor_acc_nxt = minor_acc_r - slope_ext;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
        minor_acc_nxt = minor_acc_r + slope_ext;
      end
    end

    minor_coord = minor_acc_nxt[ACC_BITS-1:FRAC_BITS];
    last_nxt    = (major_pos_nxt == major_end_nxt);

    out_data_nxt.pixel_x     = major_y_nxt ? minor_coord : major_pos_nxt;
    out_data_nxt.pixel_y     = major_y_nxt ? major_pos_nxt : minor_coord;
    out_data_nxt.pixel_value = color_nxt;
    out_data_nxt.last        = last_nxt;

    line_active_nxt = emit ? ~last_nxt : line_active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    major_y_r   <= major_y_nxt;
    step_down_r <= step_down_nxt;
    major_pos_r <= major_pos_nxt;
    major_end_r <= major_end_nxt;
    minor_acc_r <= minor_acc_nxt;
    color_r     <= color_nxt;
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
    // slope arrives in the last busy cycle of the divider
    if (div_rsp.busy) begin
      slope_r <= div_rsp.slope;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/lpr_checker.sv =====
// Port-level checks for line_pixel_rasterizer, bound to the top level.
// Depends on lpr_pkg.
module lpr_checker
  import lpr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held pixel stays put until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output pixel changed while stalled");

  // a new pixel only follows an input transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("pixel appeared without an input transfer");

  // the slope division holds the input after a start
  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_START |=> in_stall)
    else $error("input not stalled during slope division");

  // first pixel of a line is its first endpoint in the line's colour
  a_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_START |=>
      out_valid && out_data.pixel_x == $past(in_data.x_start)
      && out_data.pixel_y == $past(in_data.y_start)
      && out_data.pixel_value == $past(in_data.pixel_color))
    else $error("first pixel does not match start endpoint");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);
